// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the list engine control module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Types, sizes and opcodes of the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_WIDTH = 32;
  localparam int KW        = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [3:0]  position;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data;
    logic [4:0]  count;
  } out_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } cmd_t;

endpackage

// ===== rtl/core/sle_dpath.sv =====
// ----------------------------------------------------------------------------
// sle_dpath
// Entry registers, parallel compares, shift network and result register.
// ----------------------------------------------------------------------------
module sle_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  sle_pkg::cmd_t cmd,
  input  sle_pkg::in_t  in_data,
  output sle_pkg::out_t out_data
);

  sle_pkg::in_t  req_r;
  sle_pkg::out_t out_r;
  logic [sle_pkg::KW-1:0]    entries_r [sle_pkg::CAPACITY];
  logic [sle_pkg::KW-1:0]    entries_nxt [sle_pkg::CAPACITY];
  logic [sle_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [sle_pkg::CAPACITY-1:0] eq_r, gt_r, eq_nxt, gt_nxt;
  logic head_r, head_nxt;
  logic rd_ok_r, rd_ok_nxt;
  logic [sle_pkg::KW-1:0] rd_r;

  logic [sle_pkg::KW-1:0]    k;
  logic [sle_pkg::CNT_W-1:0] ins_at, rem_at;
  logic                      full, found, ok, do_ins, do_rem;
  logic [31:0]               data;

  assign k = req_r.key[sle_pkg::KW-1:0];

  always_comb begin
    for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
      eq_nxt[i] = (sle_pkg::CNT_W'(i) < count_r) && (entries_r[i] == k);
      gt_nxt[i] = (i != 0) && (sle_pkg::CNT_W'(i) < count_r) && (entries_r[i] > k);
    end
    head_nxt  = (count_r == '0) || (k < entries_r[0]);
    rd_ok_nxt = (int'(req_r.position) < int'(count_r));
  end

  always_comb begin
    full   = (count_r == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
    found  = |eq_r;
    ins_at = count_r;
    for (int i = sle_pkg::CAPACITY - 1; i > 0; i--) begin
      if (gt_r[i]) ins_at = sle_pkg::CNT_W'(i);
    end
    if (head_r || req_r.opcode == sle_pkg::OP_PUSH) ins_at = '0;
    rem_at = '0;
    for (int i = sle_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (eq_r[i]) rem_at = sle_pkg::CNT_W'(i);
    end
    ok     = 1'b0;
    data   = '0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    unique case (req_r.opcode)
      sle_pkg::OP_PUSH, sle_pkg::OP_INSERT: begin
        do_ins = !full;
        ok     = !full;
        data   = full ? 32'd0 : 32'(k);
      end
      sle_pkg::OP_POP: begin
        do_rem = (count_r != '0);
        ok     = (count_r != '0);
        data   = (count_r != '0) ? 32'(entries_r[0]) : 32'd0;
        rem_at = '0;
      end
      sle_pkg::OP_REMOVE: begin
        do_rem = found;
        ok     = found;
        data   = found ? 32'(k) : 32'd0;
      end
      sle_pkg::OP_SEARCH: begin
        ok   = found;
        data = found ? 32'(k) : 32'd0;
      end
      sle_pkg::OP_READ: begin
        ok   = rd_ok_r;
        data = rd_ok_r ? 32'(rd_r) : 32'd0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < sle_pkg::CAPACITY; i++) entries_nxt[i] = entries_r[i];
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
      for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
        if (sle_pkg::CNT_W'(i) == ins_at) begin
          entries_nxt[i] = k;
        end else if (sle_pkg::CNT_W'(i) > ins_at && i > 0) begin
          entries_nxt[i] = entries_r[i-1];
        end
      end
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
      for (int i = 0; i < sle_pkg::CAPACITY - 1; i++) begin
        if (sle_pkg::CNT_W'(i) >= rem_at) entries_nxt[i] = entries_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.upd) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.cmp) begin
      eq_r    <= eq_nxt;
      gt_r    <= gt_nxt;
      head_r  <= head_nxt;
      rd_ok_r <= rd_ok_nxt;
      rd_r    <= entries_r[sle_pkg::IDX_W'(req_r.position)];
    end
    if (cmd.upd) begin
      for (int i = 0; i < sle_pkg::CAPACITY; i++) entries_r[i] <= entries_nxt[i];
      out_r.ok    <= ok;
      out_r.data  <= data;
      out_r.count <= 5'(count_nxt);
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/sle_ctrl.sv =====
// ----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: accept, compare, update, and result valid tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sle_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_fin, accept;

  assign can_fin  = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || (state_r == S_UPD && can_fin));
  assign accept   = in_valid && !in_stall;

  assign cmd.load = accept;
  assign cmd.cmp  = (state_r == S_CMP);
  assign cmd.upd  = (state_r == S_UPD) && can_fin;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = can_fin ? (accept ? S_CMP : S_IDLE) : S_UPD;
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.upd || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SLE_ASSERT_NEXT(a_cmp_then_upd, clk, rst_n, state_r == S_CMP, state_r == S_UPD, "compare not followed by update")
  `SLE_ASSERT_NEXT(a_upd_sets_valid, clk, rst_n, cmd.upd, out_valid_r, "update without result valid")
  `SLE_ASSERT(a_accept_state, clk, rst_n, !accept || state_r == S_IDLE || cmd.upd, "request taken while busy")
  `SLE_ASSERT_NEXT(a_accept_cmp, clk, rst_n, accept, state_r == S_CMP, "accepted request skipped compare")

endmodule

// ===== rtl/core/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ordered key list: push, sorted insert, pop, remove, search, read.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with in_data (opcode, key, position);
// a request is taken at a clock edge with in_valid high and in_stall low.
// Every request produces exactly one result on out_valid/out_stall with
// out_data (ok, data, count), in request order.
// A taken request is registered, then compared in the compare step (all
// entries against the key in parallel), then applied in the update step
// (priority encode and one-slot shift of the entry registers), which also
// loads the result register.
// The result register frees the request side: a new request is taken in
// the update cycle as long as the previous result has been delivered.
// If the receiver stalls, the result holds and the update of the next
// request waits, which raises in_stall until the result is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sle_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sle_pkg::out_t out_data
);

  sle_pkg::cmd_t cmd;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sle_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== bench/sorted_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Self-checking bench for the bounded sorted key list.
// ----------------------------------------------------------------------------
// Requests go in through a valid/stall channel. Each accepted request is
// applied to a local copy of the list, which yields the result the block
// must return. A checker pops these expected results in order as the block
// delivers them. The stimulus starts with directed cases: empty list, sorted
// placement, lookups and a full list. It then runs long random bursts that
// fill, drain and probe the list. Both sides idle at random. One phase holds
// off the receiver long enough to back the block up.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          IDLE_PCT     = 28;
  localparam logic [2:0]  OP_SPARE_A   = 3'd6;
  localparam logic [2:0]  OP_SPARE_B   = 3'd7;
  localparam logic [31:0] KEY_MAX      = 32'hFFFF_FFFF;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_LOOKUP, MIX_NOISE} mix_mode_t;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  sle_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sle_pkg::out_t out_data;

  logic [31:0]   list_keys [sle_pkg::CAPACITY];
  int            list_count = 0;
  sle_pkg::out_t expected_results [$];
  sle_pkg::out_t want;

  int idle_pct        = IDLE_PCT;
  bit hold_start      = 1'b0;
  int hold_left       = 0;
  int cycle_count     = 0;
  int fail_count      = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int full_refusals   = 0;

  sorted_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0b actual %0b", $time, want.ok, out_data.ok);
          fail_count++;
        end
        if (out_data.data !== want.data) begin
          $display("%0t: data mismatch, expected %0h actual %0h",
                   $time, want.data, out_data.data);
          fail_count++;
        end
        if (out_data.count !== want.count) begin
          $display("%0t: count mismatch, expected %0d actual %0d",
                   $time, want.count, out_data.count);
          fail_count++;
        end
      end
    end
  end

  function automatic void list_drop(input int at);
    int i;
    for (i = at; i + 1 < list_count; i++) list_keys[i] = list_keys[i + 1];
    list_count--;
  endfunction

  function automatic sle_pkg::out_t list_apply(input sle_pkg::in_t req);
    sle_pkg::out_t res;
    int            at;
    int            i;
    res = '0;
    at = -1;
    case (req.opcode)
      sle_pkg::OP_PUSH, sle_pkg::OP_INSERT: begin
        if (list_count < sle_pkg::CAPACITY) begin
          at = 0;
          if (req.opcode == sle_pkg::OP_INSERT && list_count > 0 &&
              req.key >= list_keys[0]) begin
            at = 1;
            while (at < list_count && list_keys[at] <= req.key) at++;
          end
          for (i = list_count; i > at; i--) list_keys[i] = list_keys[i - 1];
          list_keys[at] = req.key;
          list_count++;
          res.ok = 1'b1;
          res.data = req.key;
        end else begin
          full_refusals++;
        end
      end
      sle_pkg::OP_POP: begin
        if (list_count > 0) begin
          res.ok = 1'b1;
          res.data = list_keys[0];
          list_drop(0);
        end
      end
      sle_pkg::OP_REMOVE, sle_pkg::OP_SEARCH: begin
        for (i = 0; i < list_count && at < 0; i++) begin
          if (list_keys[i] == req.key) at = i;
        end
        if (at >= 0) begin
          res.ok = 1'b1;
          res.data = req.key;
          if (req.opcode == sle_pkg::OP_REMOVE) list_drop(at);
        end
      end
      sle_pkg::OP_READ: begin
        if (req.position < list_count) begin
          res.ok = 1'b1;
          res.data = list_keys[req.position];
        end
      end
      default: ;
    endcase
    res.count = sle_pkg::CNT_W'(list_count);
    return res;
  endfunction

  function automatic sle_pkg::in_t make_request(input logic [2:0] op, input logic [31:0] k,
                                                input logic [3:0] pos);
    sle_pkg::in_t req;
    req.opcode = op;
    req.key = k;
    req.position = pos;
    return req;
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40 && list_count > 0) return list_keys[$urandom_range(list_count - 1)];
    if (r < 65) return 32'($urandom_range(15));
    if (r < 75) begin
      case ($urandom_range(3))
        0: return '0;
        1: return KEY_MAX;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_position();
    if (list_count > 0 && $urandom_range(99) < 50) return 4'($urandom_range(list_count - 1));
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [2:0] pick_opcode(input mix_mode_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MIX_FILL: begin
        if (r < 45) return sle_pkg::OP_INSERT;
        if (r < 75) return sle_pkg::OP_PUSH;
      end
      MIX_DRAIN: begin
        if (r < 40) return sle_pkg::OP_POP;
        if (r < 70) return sle_pkg::OP_REMOVE;
      end
      MIX_LOOKUP: begin
        if (r < 40) return sle_pkg::OP_SEARCH;
        if (r < 75) return sle_pkg::OP_READ;
      end
      default: return 3'($urandom_range(7));
    endcase
    return 3'($urandom_range(5));
  endfunction

  task automatic send_request(input sle_pkg::in_t req);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(list_apply(req));
    requests_sent++;
  endtask

  task automatic test_empty_list();
    send_request(make_request(sle_pkg::OP_POP, '0, '0));
    send_request(make_request(sle_pkg::OP_REMOVE, '0, '0));
    send_request(make_request(sle_pkg::OP_SEARCH, KEY_MAX, '0));
    send_request(make_request(sle_pkg::OP_READ, '0, '0));
    send_request(make_request(OP_SPARE_A, KEY_MAX, 4'hF));
    send_request(make_request(OP_SPARE_B, '0, '0));
  endtask

  task automatic test_sorted_insert();
    send_request(make_request(sle_pkg::OP_INSERT, KEY_MAX, '0));
    send_request(make_request(sle_pkg::OP_INSERT, '0, '0));
    send_request(make_request(sle_pkg::OP_INSERT, 32'd7, '0));
    send_request(make_request(sle_pkg::OP_INSERT, 32'd7, '0));
    send_request(make_request(sle_pkg::OP_INSERT, 32'd3, '0));
    send_request(make_request(sle_pkg::OP_PUSH, 32'h8000_0000, '0));
    send_request(make_request(sle_pkg::OP_INSERT, 32'd1, '0));
    send_request(make_request(sle_pkg::OP_INSERT, 32'h9000_0000, '0));
  endtask

  task automatic test_lookup();
    send_request(make_request(sle_pkg::OP_SEARCH, 32'd7, '0));
    send_request(make_request(sle_pkg::OP_SEARCH, 32'd4, '0));
    send_request(make_request(sle_pkg::OP_REMOVE, 32'd7, '0));
    send_request(make_request(sle_pkg::OP_REMOVE, 32'd4, '0));
    send_request(make_request(sle_pkg::OP_READ, '0, 4'hF));
    send_request(make_request(sle_pkg::OP_READ, '0, 4'd2));
    send_request(make_request(sle_pkg::OP_POP, '0, '0));
  endtask

  task automatic test_full_list();
    while (list_count < sle_pkg::CAPACITY) begin
      send_request(make_request(list_count[0] ? sle_pkg::OP_PUSH : sle_pkg::OP_INSERT,
                                pick_key(), '0));
    end
    send_request(make_request(sle_pkg::OP_PUSH, $urandom, '0));
    send_request(make_request(sle_pkg::OP_INSERT, '0, '0));
    send_request(make_request(sle_pkg::OP_READ, '0, 4'hF));
    send_request(make_request(sle_pkg::OP_READ, '0, '0));
    while (list_count > 0) send_request(make_request(sle_pkg::OP_POP, '0, '0));
  endtask

  task automatic test_random_mix(input int n);
    mix_mode_t mode;
    int        left;
    int        done;
    int        r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      mode = (r < 35) ? MIX_FILL : (r < 65) ? MIX_DRAIN : (r < 90) ? MIX_LOOKUP : MIX_NOISE;
      left = $urandom_range(24, 4);
      while (left > 0 && done < n) begin
        send_request(make_request(pick_opcode(mode), pick_key(), pick_position()));
        left--;
        done++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_start = 1'b1;
    repeat (24) begin
      send_request(make_request(pick_opcode(MIX_FILL), pick_key(), pick_position()));
    end
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random_mix(400);
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_sorted_insert();
    test_lookup();
    test_full_list();
    test_random_mix(700);
    test_backpressure();
    test_no_idle();
    test_random_mix(600);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests and checked %0d results; %0d inserts refused on a full list",
             requests_sent, results_checked, full_refusals);
    $display("Phases: empty list, sorted placement, lookups, full list, random bursts, hold-off");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_dpath.sv
rtl/core/sle_ctrl.sv
rtl/core/sorted_list_engine.sv
bench/sorted_list_engine_tb.sv
